>>> rtl/faa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// faa_pkg
// Shared types and constants of the frame averaging accumulator.
// ----------------------------------------------------------------------------
package faa_pkg;

  localparam int unsigned PIXELS_DEF     = 16384;
  localparam int unsigned SUM_BITS_DEF   = 24;
  localparam int unsigned COUNT_BITS_DEF = 16;

  localparam int unsigned SAMPLE_W  = 8;
  localparam int unsigned INDEX_W   = 14;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 24;
  localparam int unsigned M_TUSER_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_GRAY   = 2'd0,
    KIND_COLOUR = 2'd1,
    KIND_READ   = 2'd2,
    KIND_CLEAR  = 2'd3
  } faa_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_WRITE,
    ST_LOAD,
    ST_DIV,
    ST_RESP
  } faa_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic commit;
    logic mem_rd;
    logic mem_wr;
    logic div_start;
    logic div_step;
    logic load_out;
  } faa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    faa_kind_e kind;
    logic      in_range;
    logic      count_zero;
    logic      div_last;
    logic      out_free;
  } faa_stat_t;

endpackage

>>> rtl/faa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// faa_ctrl
// Sequencer: steps each word through decode, memory access, division and
// result hand-off.
// ----------------------------------------------------------------------------
module faa_ctrl import faa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  faa_stat_t stat_i,
  output faa_cmd_t  cmd_o
);

  faa_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        // Count and flag updates happen here; the fresh decision was taken
        // from the count at capture time.
        cmd_o.commit = 1'b1;
        state_d      = ST_RESP;
        case (stat_i.kind)
          KIND_GRAY, KIND_COLOUR: begin
            if (stat_i.in_range) begin
              cmd_o.mem_rd = 1'b1;
              state_d      = ST_WRITE;
            end
          end
          KIND_READ: begin
            if (stat_i.in_range && !stat_i.count_zero) begin
              cmd_o.mem_rd = 1'b1;
              state_d      = ST_LOAD;
            end
          end
          default: begin
            state_d = ST_RESP;
          end
        endcase
      end
      ST_WRITE: begin
        cmd_o.mem_wr = 1'b1;
        state_d      = ST_RESP;
      end
      ST_LOAD: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/faa_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// faa_datapath
// Sum memory, frame counter, three-lane restoring divider and the output
// register of the frame averaging accumulator.
// ----------------------------------------------------------------------------
module faa_datapath import faa_pkg::*; #(
  parameter int unsigned PIXELS     = PIXELS_DEF,
  parameter int unsigned SUM_BITS   = SUM_BITS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  faa_cmd_t            cmd_i,
  output faa_stat_t           stat_o,
  input  faa_kind_e           kind_i,
  input  logic [INDEX_W-1:0]  pixel_index_i,
  input  logic [SAMPLE_W-1:0] red_or_gray_i,
  input  logic [SAMPLE_W-1:0] green_i,
  input  logic [SAMPLE_W-1:0] blue_i,
  input  logic                end_of_frame_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [SAMPLE_W-1:0] red_average_o,
  output logic [SAMPLE_W-1:0] green_average_o,
  output logic [SAMPLE_W-1:0] blue_average_o,
  output logic                colour_seen_o,
  output logic                status_o
);

  localparam int unsigned ADDR_W  = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int unsigned IDX_W   = (ADDR_W > INDEX_W) ? ADDR_W : INDEX_W;
  localparam int unsigned LANES   = 3;
  localparam int unsigned WORD_W  = LANES * SUM_BITS;
  localparam int unsigned DCNT_W  = $clog2(SUM_BITS);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Captured item.
  faa_kind_e           kind_q;
  logic [ADDR_W-1:0]   addr_q;
  logic                inside_q;
  logic                fresh_q;
  logic                eof_q;
  logic [SAMPLE_W-1:0] sample_q [LANES];

  logic [IDX_W-1:0]    idx_wide;

  // Persistent state.
  logic [COUNT_BITS-1:0] count_q;
  logic                  colour_q;

  // Sum memory: one word holds the red, green and blue sums of a pixel.
  logic [WORD_W-1:0] mem [PIXELS];
  logic [WORD_W-1:0] rdata_q;
  logic [WORD_W-1:0] wdata;

  // Divider.
  logic [SUM_BITS-1:0]   dvd_q  [LANES];
  logic [COUNT_BITS-1:0] rem_q  [LANES];
  logic [SAMPLE_W-1:0]   quot_q [LANES];
  logic [DCNT_W-1:0]     dcnt_q;
  logic [COUNT_BITS:0]   shifted [LANES];
  logic                  ge      [LANES];
  logic [COUNT_BITS:0]   diff    [LANES];

  // Output register.
  logic                out_valid_q;
  logic [SAMPLE_W-1:0] avg_q [LANES];
  logic                colour_out_q;
  logic                status_q;
  logic                use_div;

  assign idx_wide = IDX_W'(pixel_index_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q      <= kind_i;
      addr_q      <= idx_wide[ADDR_W-1:0];
      inside_q    <= 32'(pixel_index_i) < 32'(PIXELS);
      fresh_q     <= (count_q == '0);
      eof_q       <= end_of_frame_i;
      sample_q[0] <= red_or_gray_i;
      sample_q[1] <= (kind_i == KIND_GRAY) ? red_or_gray_i : green_i;
      sample_q[2] <= (kind_i == KIND_GRAY) ? red_or_gray_i : blue_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      colour_q <= 1'b0;
    end else if (cmd_i.commit) begin
      case (kind_q)
        KIND_GRAY, KIND_COLOUR: begin
          if (kind_q == KIND_COLOUR) begin
            colour_q <= 1'b1;
          end
          if (eof_q && count_q != COUNT_MAX) begin
            count_q <= count_q + 1'b1;
          end
        end
        KIND_CLEAR: begin
          count_q  <= '0;
          colour_q <= 1'b0;
        end
        default: begin
          count_q <= count_q;
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      wdata[i*SUM_BITS +: SUM_BITS] = fresh_q ? SUM_BITS'(sample_q[i])
          : rdata_q[i*SUM_BITS +: SUM_BITS] + SUM_BITS'(sample_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      mem[addr_q] <= wdata;
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= mem[addr_q];
    end
  end

  // One quotient bit per lane and cycle, most significant first. Only the
  // low eight quotient bits are kept.
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      shifted[i] = {rem_q[i], dvd_q[i][SUM_BITS-1]};
      diff[i]    = shifted[i] - {1'b0, count_q};
      ge[i]      = shifted[i] >= {1'b0, count_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      for (int i = 0; i < LANES; i++) begin
        dvd_q[i]  <= rdata_q[i*SUM_BITS +: SUM_BITS];
        rem_q[i]  <= '0;
        quot_q[i] <= '0;
      end
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      for (int i = 0; i < LANES; i++) begin
        dvd_q[i]  <= {dvd_q[i][SUM_BITS-2:0], 1'b0};
        rem_q[i]  <= ge[i] ? diff[i][COUNT_BITS-1:0] : shifted[i][COUNT_BITS-1:0];
        quot_q[i] <= {quot_q[i][SAMPLE_W-2:0], ge[i]};
      end
      dcnt_q <= dcnt_q + 1'b1;
    end
  end

  assign use_div = (kind_q == KIND_READ) && inside_q && (count_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      for (int i = 0; i < LANES; i++) begin
        avg_q[i] <= use_div ? quot_q[i] : '0;
      end
      colour_out_q <= colour_q;
      status_q     <= (kind_q == KIND_READ) && (count_q == '0);
    end
  end

  assign stat_o.kind       = kind_q;
  assign stat_o.in_range   = inside_q;
  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.div_last   = (dcnt_q == DCNT_W'(SUM_BITS - 1));
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign red_average_o   = avg_q[0];
  assign green_average_o = avg_q[1];
  assign blue_average_o  = avg_q[2];
  assign colour_seen_o   = colour_out_q;
  assign status_o        = status_q;

endmodule

>>> rtl/frame_average_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_average_accumulator
// Per-pixel RGB sums over a run of frames, read back as averages.
// ----------------------------------------------------------------------------
// Every input word gives exactly one output word. The block works on one word
// at a time and takes a new one only while idle. A clear, a read with no frame
// counted and any word outside the frame go from dispatch straight to the
// result state; an add inside the frame first reads and writes the sum
// memory, and a read that divides first runs the restoring divider, which
// finds one quotient bit per cycle for the three colour lanes at once. The
// result reaches the output register in the same cycle as the block turns
// idle again. A new word is taken as soon as the previous result sits in the
// output register, even while it waits; a result that finds the output
// register still full stalls the block until the receiver takes the older word.
// The sum memory (PIXELS words of three sums) is not cleared at reset; the
// first add to a pixel while no frame is counted writes its sums.
module frame_average_accumulator import faa_pkg::*; #(
  parameter int unsigned PIXELS     = PIXELS_DEF,
  parameter int unsigned SUM_BITS   = SUM_BITS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // pixel_index[13:0], red_or_gray[21:14], green[29:22], blue[37:30], zero
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // kind[1:0]
  input  logic [KIND_W-1:0]    s_axis_tuser,
  // end_of_frame
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // red_average[7:0], green_average[15:8], blue_average[23:16]
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // colour_seen[0], status[1]
  output logic [M_TUSER_W-1:0] m_axis_tuser
);

  faa_cmd_t            cmd;
  faa_stat_t           stat;
  logic [SAMPLE_W-1:0] red_avg;
  logic [SAMPLE_W-1:0] green_avg;
  logic [SAMPLE_W-1:0] blue_avg;
  logic                colour_seen;
  logic                status;

  faa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  faa_datapath #(
    .PIXELS     (PIXELS),
    .SUM_BITS   (SUM_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .kind_i          (faa_kind_e'(s_axis_tuser)),
    .pixel_index_i   (s_axis_tdata[13:0]),
    .red_or_gray_i   (s_axis_tdata[21:14]),
    .green_i         (s_axis_tdata[29:22]),
    .blue_i          (s_axis_tdata[37:30]),
    .end_of_frame_i  (s_axis_tlast),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .red_average_o   (red_avg),
    .green_average_o (green_avg),
    .blue_average_o  (blue_avg),
    .colour_seen_o   (colour_seen),
    .status_o        (status)
  );

  assign m_axis_tdata = {blue_avg, green_avg, red_avg};
  assign m_axis_tuser = {status, colour_seen};

  // Only one word is in flight, so acceptance closes the input in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a word is in flight");

  // A read with no frames counted reports zero averages.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == '0)
    else $error("no-frame read with nonzero averages");

  // The divider never starts with a zero divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> !stat.count_zero)
    else $error("division started with zero frame count");

  // The sum memory is written only at addresses inside the frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mem_wr |-> stat.in_range && $past(cmd.mem_rd))
    else $error("sum write without a preceding in-range read");

endmodule
